FILE: sv/bfha_pkg.sv
// package with constants, types and op codes of the best-fit heap allocator
`timescale 1ns / 1ps
package bfha_pkg;
    localparam int HEAP_BYTES_DEF = 65536;
    localparam int META_BYTES_DEF = 32;
    localparam int MAX_BLOCKS_DEF = 256;
    localparam logic [7:0] SLACK_RESET = 8'd8;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_REALLOC = 2'd2,
        OP_RESET   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_BADFREE = 2'd2,
        ST_BADREAL = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_FIND_RD,
        S_FIND_CHK,
        S_FIT_RD,
        S_FIT_CHK,
        S_FIT_DONE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_SPLIT_WR,
        S_GRANT_WR,
        S_FREE_WR,
        S_MRG_RD0,
        S_MRG_RD1,
        S_MRG_CHK,
        S_MRG_WR,
        S_CMP_RD,
        S_CMP_WR,
        S_REALLOC_FREE,
        S_RESET_WR,
        S_OUT
    } t_state;
endpackage

FILE: sv/bfha_if.sv
// valid/ready channel interface carrying one word
`timescale 1ns / 1ps
interface bfha_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/bfha_table.sv
// block table memory: start, size and free flag per entry
`timescale 1ns / 1ps
module bfha_table import bfha_pkg::*; #(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
    parameter int AW = $clog2(MAX_BLOCKS)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [16:0]   i_wstart,
    input  logic [16:0]   i_wsize,
    input  logic          i_wfree,
    input  logic [AW-1:0] i_raddr,
    output logic [16:0]   o_rstart,
    output logic [16:0]   o_rsize,
    output logic          o_rfree
);
    logic [34:0] r_mem [MAX_BLOCKS];
    logic [34:0] r_q;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wfree, i_wsize, i_wstart};
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rstart = r_q[16:0];
    assign o_rsize  = r_q[33:17];
    assign o_rfree  = r_q[34];
endmodule

FILE: sv/best_fit_heap_allocator.sv
// top level: sequencer over the block table memory
// each entry scanned or shifted takes a read state, then a check or write state; each entry
// checked in the merge pass takes two reads and a check; one word at a time: a new word is
// taken only in idle; alloc, free and a moving realloc last as long as their table walks
// reset: synchronous active low; counters and the table length reset at once,
// entry 0 is rewritten in state S_RESET_WR after reset, before any word is taken
`timescale 1ns / 1ps
module best_fit_heap_allocator import bfha_pkg::*; #(
    parameter int HEAP_BYTES = HEAP_BYTES_DEF,
    parameter int META_BYTES = META_BYTES_DEF,
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    bfha_if.sink       i_req,
    bfha_if.source     o_rsp
);
    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int CW = AW + 1;
    localparam logic [16:0] META = 17'(META_BYTES);
    localparam logic [16:0] HEAP_PAY = 17'(HEAP_BYTES - META_BYTES);
    localparam logic [CW-1:0] MAXB = CW'(MAX_BLOCKS);

    // request fields
    logic [1:0]  w_op;
    logic [23:0] w_size;
    logic [15:0] w_addr;
    logic        w_pres;
    assign w_op   = i_req.data[42:41];
    assign w_size = i_req.data[40:17];
    assign w_addr = i_req.data[16:1];
    assign w_pres = i_req.data[0];

    t_state r_state, n_state;
    logic [7:0]  r_slack;
    logic [1:0]  r_op;
    logic [23:0] r_size;
    logic [15:0] r_addr;
    logic        r_pres;
    logic [CW-1:0] r_nblk;
    logic [31:0] r_alloc_b, r_free_b, r_fail;
    logic [15:0] r_live;
    logic [CW-1:0] r_i, r_j;
    logic [CW-1:0] r_best;
    logic [16:0] r_bstart, r_bsize, r_bwaste;
    logic        r_found;
    logic        r_split;
    logic [16:0] r_s0, r_z0, r_z1;
    logic        r_f0;
    logic [15:0] r_raddr;
    logic        r_rpres;
    t_status     r_status;
    logic        r_realloc;  // alloc is part of a realloc, free old afterwards
    logic        r_orsp_v;
    logic [15:0] r_res_addr;
    logic        r_res_pres;
    t_status     r_res_st;
    logic [31:0] r_res_alloc, r_res_free, r_res_fail;
    logic [15:0] r_res_live;
    logic [8:0]  r_res_nblk;

    // memory port
    logic          m_we;
    logic [AW-1:0] m_waddr, m_raddr;
    logic [16:0]   m_wstart, m_wsize, m_rstart, m_rsize;
    logic          m_wfree, m_rfree;

    bfha_table #(.MAX_BLOCKS(MAX_BLOCKS), .AW(AW)) u_table (
        .i_clk(i_clk), .i_we(m_we), .i_waddr(m_waddr), .i_wstart(m_wstart),
        .i_wsize(m_wsize), .i_wfree(m_wfree), .i_raddr(m_raddr),
        .o_rstart(m_rstart), .o_rsize(m_rsize), .o_rfree(m_rfree)
    );

    // derived compares
    logic [24:0] w_thr;
    logic        w_bad_size, w_hit, w_fits, w_split;
    logic [16:0] w_waste, w_sz17;
    assign w_sz17 = r_size[16:0];
    assign w_bad_size = (r_size == 24'd0) || (r_size > 24'(HEAP_PAY));
    assign w_hit = ((m_rstart + META) == {1'b0, r_addr});
    assign w_fits = m_rfree && (m_rsize >= w_sz17);
    assign w_waste = m_rsize - w_sz17;
    assign w_thr = 25'(r_size) + 25'(META) + 25'(r_slack);
    assign w_split = (25'(r_bsize) > w_thr) && (r_nblk < MAXB);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_RESET_WR: n_state = (t_op'(r_op) == OP_RESET) ? S_OUT : S_IDLE;
            S_IDLE: if (i_req.valid && i_req.ready) n_state = S_DECODE;
            S_DECODE: begin
                case (t_op'(r_op))
                    OP_RESET: n_state = S_RESET_WR;
                    OP_FREE:  n_state = r_pres ? S_FIND_RD : S_OUT;
                    OP_REALLOC: n_state = !r_pres ? (w_bad_size ? S_OUT : S_FIT_RD)
                                                  : S_FIND_RD;
                    default: n_state = w_bad_size ? S_OUT : S_FIT_RD;
                endcase
            end
            S_FIND_RD: n_state = S_FIND_CHK;
            S_FIND_CHK: begin
                if (w_hit) begin
                    if (m_rfree) n_state = S_OUT;
                    else if (t_op'(r_op) == OP_FREE || r_size == 24'd0 || r_realloc)
                        n_state = S_FREE_WR;
                    else if (r_size <= 24'(m_rsize)) n_state = S_OUT;
                    else n_state = w_bad_size ? S_OUT : S_FIT_RD;
                end else if (r_i + 1'b1 >= r_nblk) n_state = S_OUT;
                else n_state = S_FIND_RD;
            end
            S_FIT_RD: n_state = S_FIT_CHK;
            S_FIT_CHK: begin
                if (w_fits && w_waste == 17'd0) n_state = S_FIT_DONE;
                else if (r_i + 1'b1 >= r_nblk) n_state = S_FIT_DONE;
                else n_state = S_FIT_RD;
            end
            S_FIT_DONE: begin
                if (!r_found) n_state = S_OUT;
                else if (w_split)
                    n_state = (r_nblk > r_best + 1'b1) ? S_SHIFT_RD : S_SPLIT_WR;
                else n_state = S_GRANT_WR;
            end
            S_SHIFT_RD: n_state = S_SHIFT_WR;
            S_SHIFT_WR: n_state = (r_j - 1'b1 > r_best + 1'b1) ? S_SHIFT_RD : S_SPLIT_WR;
            S_SPLIT_WR: n_state = S_GRANT_WR;
            S_GRANT_WR: n_state = r_realloc ? S_REALLOC_FREE : S_OUT;
            S_REALLOC_FREE: n_state = S_FIND_RD;
            S_FREE_WR: n_state = (r_nblk > 1) ? S_MRG_RD0 : S_OUT;
            S_MRG_RD0: n_state = S_MRG_RD1;
            S_MRG_RD1: n_state = S_MRG_CHK;
            S_MRG_CHK: begin
                if (r_f0 && m_rfree) n_state = S_MRG_WR;
                else if (r_i + 2'd2 >= r_nblk) n_state = S_OUT;
                else n_state = S_MRG_RD0;
            end
            S_MRG_WR: n_state = (r_i + 2'd2 < r_nblk) ? S_CMP_RD : S_OUT;
            S_CMP_RD: n_state = S_CMP_WR;
            S_CMP_WR: n_state = (r_j + 2'd2 < r_nblk) ? S_CMP_RD : S_MRG_RD0;
            S_OUT: n_state = r_orsp_v ? S_OUT : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // memory control
    always_comb begin
        m_we = 1'b0;
        m_waddr = '0;
        m_wstart = r_bstart;
        m_wsize = r_bsize;
        m_wfree = 1'b0;
        m_raddr = r_i[AW-1:0];
        case (r_state)
            S_RESET_WR: begin
                m_we = 1'b1; m_wstart = '0; m_wsize = HEAP_PAY; m_wfree = 1'b1;
            end
            S_SHIFT_RD: m_raddr = AW'(r_j - 1'b1);
            S_SHIFT_WR: begin
                m_we = 1'b1; m_waddr = r_j[AW-1:0];
                m_wstart = m_rstart; m_wsize = m_rsize; m_wfree = m_rfree;
            end
            S_SPLIT_WR: begin
                m_we = 1'b1; m_waddr = AW'(r_best + 1'b1);
                m_wstart = r_bstart + META + w_sz17;
                m_wsize = r_bsize - w_sz17 - META; m_wfree = 1'b1;
            end
            S_GRANT_WR: begin
                m_we = 1'b1; m_waddr = r_best[AW-1:0];
                m_wsize = r_split ? w_sz17 : r_bsize;
            end
            S_FREE_WR: begin
                m_we = 1'b1; m_waddr = r_best[AW-1:0]; m_wfree = 1'b1;
            end
            S_MRG_RD0: m_raddr = r_i[AW-1:0];
            S_MRG_RD1: m_raddr = AW'(r_i + 1'b1);
            S_MRG_WR: begin
                m_we = 1'b1; m_waddr = r_i[AW-1:0];
                m_wstart = r_s0; m_wsize = r_z0 + META + r_z1; m_wfree = 1'b1;
            end
            S_CMP_RD: m_raddr = AW'(r_j + 2'd2);
            S_CMP_WR: begin
                m_we = 1'b1; m_waddr = AW'(r_j + 1'b1);
                m_wstart = m_rstart; m_wsize = m_rsize; m_wfree = m_rfree;
            end
            default: ;
        endcase
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_orsp_v;
    assign o_rsp.data = {r_res_addr, r_res_pres, r_res_st, r_res_alloc, r_res_free,
                         r_res_live, r_res_nblk, r_res_fail};

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RESET_WR;
            r_op <= OP_ALLOC;
            r_slack <= SLACK_RESET;
            r_nblk <= CW'(1);
            r_alloc_b <= '0;
            r_free_b <= 32'(HEAP_PAY);
            r_live <= '0;
            r_fail <= '0;
            r_orsp_v <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_slack <= i_cfg_data;
            if (o_rsp.valid && o_rsp.ready) r_orsp_v <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    r_op <= w_op; r_size <= w_size; r_addr <= w_addr; r_pres <= w_pres;
                    r_rpres <= 1'b0; r_raddr <= '0; r_status <= ST_OK;
                    r_realloc <= 1'b0; r_i <= '0; r_found <= 1'b0;
                end
                S_DECODE: begin
                    r_i <= '0;
                    if (t_op'(r_op) == OP_RESET) begin
                        r_nblk <= CW'(1); r_alloc_b <= '0; r_free_b <= 32'(HEAP_PAY);
                        r_live <= '0; r_fail <= '0;
                    end else if ((t_op'(r_op) == OP_ALLOC ||
                                 (t_op'(r_op) == OP_REALLOC && !r_pres)) && w_bad_size) begin
                        r_fail <= r_fail + 1'b1; r_status <= ST_NOFIT;
                    end
                end
                S_FIND_CHK: begin
                    if (w_hit) begin
                        r_best <= r_i; r_bstart <= m_rstart; r_bsize <= m_rsize; r_i <= '0;
                        if (m_rfree) begin
                            if (!r_realloc)
                                r_status <= (t_op'(r_op) == OP_REALLOC && r_size != 24'd0)
                                            ? ST_BADREAL : ST_BADFREE;
                        end else if (t_op'(r_op) == OP_FREE || r_size == 24'd0 ||
                                     r_realloc) begin
                            r_alloc_b <= r_alloc_b - 32'(m_rsize + META);
                            r_free_b <= r_free_b + 32'(m_rsize + META);
                            r_live <= r_live - 1'b1;
                        end else if (r_size <= 24'(m_rsize)) begin
                            r_raddr <= r_addr; r_rpres <= 1'b1;
                        end else if (w_bad_size) begin
                            r_fail <= r_fail + 1'b1; r_status <= ST_NOFIT;
                        end else begin
                            r_realloc <= 1'b1;
                        end
                    end else begin
                        r_i <= r_i + 1'b1;
                        if (r_i + 1'b1 >= r_nblk && !r_realloc)
                            r_status <= (t_op'(r_op) == OP_REALLOC && r_size != 24'd0)
                                        ? ST_BADREAL : ST_BADFREE;
                    end
                end
                S_FIT_CHK: begin
                    r_i <= r_i + 1'b1;
                    if (w_fits && (!r_found || w_waste < r_bwaste)) begin
                        r_found <= 1'b1; r_best <= r_i; r_bwaste <= w_waste;
                        r_bstart <= m_rstart; r_bsize <= m_rsize;
                    end
                end
                S_FIT_DONE: begin
                    r_j <= r_nblk;
                    r_split <= w_split;
                    if (!r_found) begin
                        r_fail <= r_fail + 1'b1; r_status <= ST_NOFIT; r_realloc <= 1'b0;
                    end
                end
                S_SHIFT_WR: r_j <= r_j - 1'b1;
                S_SPLIT_WR: r_nblk <= r_nblk + 1'b1;
                S_GRANT_WR: begin
                    r_alloc_b <= r_alloc_b + 32'(r_size) + 32'(META);
                    r_free_b <= r_free_b - 32'(r_size) - 32'(META);
                    r_live <= r_live + 1'b1;
                    r_raddr <= 16'(r_bstart + META); r_rpres <= 1'b1;
                end
                S_REALLOC_FREE: r_i <= '0;
                S_FREE_WR: r_i <= '0;
                S_MRG_RD1: begin
                    r_s0 <= m_rstart; r_z0 <= m_rsize; r_f0 <= m_rfree;
                end
                S_MRG_CHK: begin
                    r_z1 <= m_rsize;
                    if (!(r_f0 && m_rfree)) r_i <= r_i + 1'b1;
                end
                S_MRG_WR: begin
                    r_j <= r_i; r_nblk <= r_nblk - 1'b1;
                end
                S_CMP_WR: r_j <= r_j + 1'b1;
                S_OUT: begin
                    if (!r_orsp_v) begin
                        r_orsp_v <= 1'b1;
                        r_res_addr <= r_rpres ? r_raddr : 16'd0;
                        r_res_pres <= r_rpres;
                        r_res_st <= r_status;
                        r_res_alloc <= r_alloc_b;
                        r_res_free <= r_free_b;
                        r_res_live <= r_live;
                        r_res_nblk <= 9'(r_nblk);
                        r_res_fail <= r_fail;
                    end
                end
                default: ;
            endcase
        end
    end

    // checks on the sequencer
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> !r_orsp_v || r_state == S_IDLE)
        else $error("ready outside idle");
    a_nblk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nblk >= CW'(1) && r_nblk <= MAXB)
        else $error("block count out of range");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_orsp_v && !o_rsp.ready |=> r_orsp_v && $stable(r_res_st))
        else $error("result dropped");
endmodule
